FILE: rtl/core/qam_pkg.sv
`default_nettype none

package qam_pkg;

   // Number of components in one quaternion.
   localparam int NUM_COMP = 4;

   // Component positions within a quaternion array.
   localparam int COMP_X = 0;
   localparam int COMP_Y = 1;
   localparam int COMP_Z = 2;
   localparam int COMP_W = 3;

   // Pipeline depth from an accepted input word to its result word.
   localparam int PIPE_DEPTH = 4;

endpackage

`default_nettype wire

FILE: rtl/core/qam_req_if.sv
`default_nettype none

// Input channel: one pair of quaternions per word.
interface qam_req_if #(
   parameter int COMP_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] p_x;
   logic signed [COMP_WIDTH-1:0] p_y;
   logic signed [COMP_WIDTH-1:0] p_z;
   logic signed [COMP_WIDTH-1:0] p_w;
   logic signed [COMP_WIDTH-1:0] q_x;
   logic signed [COMP_WIDTH-1:0] q_y;
   logic signed [COMP_WIDTH-1:0] q_z;
   logic signed [COMP_WIDTH-1:0] q_w;

   modport source (
      output valid, p_x, p_y, p_z, p_w, q_x, q_y, q_z, q_w,
      input  ready
   );

   modport sink (
      input  valid, p_x, p_y, p_z, p_w, q_x, q_y, q_z, q_w,
      output ready
   );
endinterface

// Result channel: one product quaternion and its flags per word.
interface qam_rsp_if #(
   parameter int COMP_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] r_x;
   logic signed [COMP_WIDTH-1:0] r_y;
   logic signed [COMP_WIDTH-1:0] r_z;
   logic signed [COMP_WIDTH-1:0] r_w;
   logic                         q_flipped;
   logic                         saturated;

   modport source (
      output valid, r_x, r_y, r_z, r_w, q_flipped, saturated,
      input  ready
   );

   modport sink (
      input  valid, r_x, r_y, r_z, r_w, q_flipped, saturated,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/qam_mult.sv
`default_nettype none

// Stage one: all sixteen cross products p[i] * q[j], registered.
module qam_mult #(
   parameter int COMP_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic signed [COMP_WIDTH-1:0]   p [qam_pkg::NUM_COMP],
   input  wire logic signed [COMP_WIDTH-1:0]   q [qam_pkg::NUM_COMP],
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic signed [2*COMP_WIDTH-1:0]      prod [qam_pkg::NUM_COMP][qam_pkg::NUM_COMP]
);
   localparam int PW = 2 * COMP_WIDTH;

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [PW-1:0] prod_ff [qam_pkg::NUM_COMP][qam_pkg::NUM_COMP];
   logic signed [PW-1:0] prod_in [qam_pkg::NUM_COMP][qam_pkg::NUM_COMP];

   // The stage takes a word when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Exact signed products, one multiplier per pair.
   always_comb begin
      for (int i = 0; i < qam_pkg::NUM_COMP; i++) begin
         for (int j = 0; j < qam_pkg::NUM_COMP; j++) begin
            prod_in[i][j] = PW'(p[i]) * PW'(q[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;
endmodule

`default_nettype wire

FILE: rtl/core/qam_sum.sv
`default_nettype none

// Stage two: dot product sign and the four raw Hamilton sums, exact.
module qam_sum #(
   parameter int COMP_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic signed [2*COMP_WIDTH-1:0] prod [qam_pkg::NUM_COMP][qam_pkg::NUM_COMP],
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic signed [2*COMP_WIDTH+1:0]      sum [qam_pkg::NUM_COMP],
   output logic                                flip
);
   localparam int SW = 2 * COMP_WIDTH + 2;

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [SW-1:0] sum_ff [qam_pkg::NUM_COMP];
   logic signed [SW-1:0] sum_in [qam_pkg::NUM_COMP];
   logic signed [SW-1:0] dot;
   logic                 flip_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Sums of four products; the widened width keeps every sum exact.
   always_comb begin
      dot = SW'(prod[qam_pkg::COMP_X][qam_pkg::COMP_X])
          + SW'(prod[qam_pkg::COMP_Y][qam_pkg::COMP_Y])
          + SW'(prod[qam_pkg::COMP_Z][qam_pkg::COMP_Z])
          + SW'(prod[qam_pkg::COMP_W][qam_pkg::COMP_W]);

      sum_in[qam_pkg::COMP_X] = SW'(prod[qam_pkg::COMP_X][qam_pkg::COMP_W])
                              + SW'(prod[qam_pkg::COMP_Y][qam_pkg::COMP_Z])
                              - SW'(prod[qam_pkg::COMP_Z][qam_pkg::COMP_Y])
                              + SW'(prod[qam_pkg::COMP_W][qam_pkg::COMP_X]);

      sum_in[qam_pkg::COMP_Y] = SW'(prod[qam_pkg::COMP_Y][qam_pkg::COMP_W])
                              - SW'(prod[qam_pkg::COMP_X][qam_pkg::COMP_Z])
                              + SW'(prod[qam_pkg::COMP_Z][qam_pkg::COMP_X])
                              + SW'(prod[qam_pkg::COMP_W][qam_pkg::COMP_Y]);

      sum_in[qam_pkg::COMP_Z] = SW'(prod[qam_pkg::COMP_X][qam_pkg::COMP_Y])
                              - SW'(prod[qam_pkg::COMP_Y][qam_pkg::COMP_X])
                              + SW'(prod[qam_pkg::COMP_Z][qam_pkg::COMP_W])
                              + SW'(prod[qam_pkg::COMP_W][qam_pkg::COMP_Z]);

      sum_in[qam_pkg::COMP_W] = SW'(prod[qam_pkg::COMP_W][qam_pkg::COMP_W])
                              - SW'(prod[qam_pkg::COMP_X][qam_pkg::COMP_X])
                              - SW'(prod[qam_pkg::COMP_Y][qam_pkg::COMP_Y])
                              - SW'(prod[qam_pkg::COMP_Z][qam_pkg::COMP_Z]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // A negative dot product means q is negated; a zero leaves it alone.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sum_ff  <= sum_in;
         flip_ff <= dot[SW-1];
      end
   end

   assign out_valid = valid_ff;
   assign sum       = sum_ff;
   assign flip      = flip_ff;
endmodule

`default_nettype wire

FILE: rtl/core/qam_round.sv
`default_nettype none

// Stages three and four: sign alignment and half-up rounding, then the
// fraction shift and saturation into the output register.
module qam_round #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic signed [2*COMP_WIDTH+1:0] sum [qam_pkg::NUM_COMP],
   input  wire logic                           flip,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic signed [COMP_WIDTH-1:0]        r [qam_pkg::NUM_COMP],
   output logic                                q_flipped,
   output logic                                saturated
);
   localparam int SW = 2 * COMP_WIDTH + 2;
   localparam int RW = (2 * COMP_WIDTH + 3 > FRAC_BITS + 2) ?
                       2 * COMP_WIDTH + 3 : FRAC_BITS + 2;

   localparam logic signed [RW-1:0] HALF =
      {{(RW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [RW-1:0] MAX_POS =
      {{(RW-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] MIN_NEG =
      {{(RW-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};

   logic                         rnd_valid_ff;
   logic                         rnd_valid_in;
   logic                         rnd_ready;
   logic signed [RW-1:0]         rnd_ff [qam_pkg::NUM_COMP];
   logic signed [RW-1:0]         rnd_in [qam_pkg::NUM_COMP];
   logic                         flip_ff;

   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic signed [RW-1:0]         shifted [qam_pkg::NUM_COMP];
   logic signed [COMP_WIDTH-1:0] r_ff [qam_pkg::NUM_COMP];
   logic signed [COMP_WIDTH-1:0] r_in [qam_pkg::NUM_COMP];
   logic [qam_pkg::NUM_COMP-1:0] clip;
   logic                         q_flipped_ff;
   logic                         saturated_ff;

   // Handshake of the two register stages.
   assign rnd_ready    = !out_valid_ff || out_ready;
   assign in_ready     = !rnd_valid_ff || rnd_ready;
   assign rnd_valid_in = in_ready ? in_valid : rnd_valid_ff;
   assign out_valid_in = rnd_ready ? rnd_valid_ff : out_valid_ff;

   // Negate the exact sum when q was flipped, then add half an LSB.
   always_comb begin
      logic signed [RW-1:0] ext;
      for (int i = 0; i < qam_pkg::NUM_COMP; i++) begin
         ext       = {{(RW-SW){sum[i][SW-1]}}, sum[i]};
         rnd_in[i] = (flip ? -ext : ext) + HALF;
      end
   end

   // Drop the fraction bits and clip to the component range.
   always_comb begin
      for (int i = 0; i < qam_pkg::NUM_COMP; i++) begin
         shifted[i] = rnd_ff[i] >>> FRAC_BITS;
         if (shifted[i] > MAX_POS) begin
            r_in[i] = MAX_POS[COMP_WIDTH-1:0];
            clip[i] = 1'b1;
         end else if (shifted[i] < MIN_NEG) begin
            r_in[i] = MIN_NEG[COMP_WIDTH-1:0];
            clip[i] = 1'b1;
         end else begin
            r_in[i] = shifted[i][COMP_WIDTH-1:0];
            clip[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rnd_valid_ff <= rnd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rnd_ff  <= rnd_in;
         flip_ff <= flip;
      end
   end

   always_ff @(posedge clock) begin
      if (rnd_valid_ff && rnd_ready) begin
         r_ff         <= r_in;
         q_flipped_ff <= flip_ff;
         saturated_ff <= |clip;
      end
   end

   assign out_valid = out_valid_ff;
   assign r         = r_ff;
   assign q_flipped = q_flipped_ff;
   assign saturated = saturated_ff;
endmodule

`default_nettype wire

FILE: rtl/core/quaternion_align_multiply_core.sv
`default_nettype none

// Hamilton product p * q of two fixed-point quaternions, with q first
// negated when the dot product p . q is negative so that both lie in the
// same hemisphere (a zero dot product leaves q as it is). Components are
// signed COMP_WIDTH-bit values with FRAC_BITS fraction bits; all products
// and sums are exact, and each result component is rounded half up and
// saturated, with saturated set when any component clipped and q_flipped
// set when q was negated. The block is a four-stage pipeline (multiply,
// sum, align and round, shift and saturate): it takes one word per cycle
// while the result side does not stall, and a result word moves through
// the stage registers in that order once its input word is accepted. Each
// stage holds its word until the next stage frees, so the input side keeps
// taking words while bubbles remain.
module quaternion_align_multiply_core #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input wire logic    clock,
   input wire logic    reset,
   qam_req_if.sink     req_chan,
   qam_rsp_if.source   rsp_chan
);
   localparam int PW = 2 * COMP_WIDTH;
   localparam int SW = 2 * COMP_WIDTH + 2;

   logic signed [COMP_WIDTH-1:0] p [qam_pkg::NUM_COMP];
   logic signed [COMP_WIDTH-1:0] q [qam_pkg::NUM_COMP];
   logic signed [PW-1:0]         prod [qam_pkg::NUM_COMP][qam_pkg::NUM_COMP];
   logic signed [SW-1:0]         sum [qam_pkg::NUM_COMP];
   logic signed [COMP_WIDTH-1:0] r [qam_pkg::NUM_COMP];
   logic                         flip;
   logic                         mult_valid;
   logic                         mult_ready;
   logic                         sum_valid;
   logic                         sum_ready;

   // Gather the input word into component arrays.
   assign p[qam_pkg::COMP_X] = req_chan.p_x;
   assign p[qam_pkg::COMP_Y] = req_chan.p_y;
   assign p[qam_pkg::COMP_Z] = req_chan.p_z;
   assign p[qam_pkg::COMP_W] = req_chan.p_w;
   assign q[qam_pkg::COMP_X] = req_chan.q_x;
   assign q[qam_pkg::COMP_Y] = req_chan.q_y;
   assign q[qam_pkg::COMP_Z] = req_chan.q_z;
   assign q[qam_pkg::COMP_W] = req_chan.q_w;

   qam_mult #(
      .COMP_WIDTH (COMP_WIDTH)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .p         (p),
      .q         (q),
      .out_valid (mult_valid),
      .out_ready (mult_ready),
      .prod      (prod)
   );

   qam_sum #(
      .COMP_WIDTH (COMP_WIDTH)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_valid),
      .in_ready  (mult_ready),
      .prod      (prod),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .sum       (sum),
      .flip      (flip)
   );

   qam_round #(
      .COMP_WIDTH (COMP_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .sum       (sum),
      .flip      (flip),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .r         (r),
      .q_flipped (rsp_chan.q_flipped),
      .saturated (rsp_chan.saturated)
   );

   // Scatter the result components onto the output word.
   assign rsp_chan.r_x = r[qam_pkg::COMP_X];
   assign rsp_chan.r_y = r[qam_pkg::COMP_Y];
   assign rsp_chan.r_z = r[qam_pkg::COMP_Z];
   assign rsp_chan.r_w = r[qam_pkg::COMP_W];
endmodule

`default_nettype wire

FILE: rtl/core/qam_checker.sv
`default_nettype none

// Port-level checks for the quaternion multiply core.
module qam_checker #(
   parameter int COMP_WIDTH = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [COMP_WIDTH-1:0] r_x,
   input wire logic signed [COMP_WIDTH-1:0] r_y,
   input wire logic signed [COMP_WIDTH-1:0] r_z,
   input wire logic signed [COMP_WIDTH-1:0] r_w,
   input wire logic                         q_flipped,
   input wire logic                         saturated
);
   localparam logic signed [COMP_WIDTH-1:0] MAX_POS = {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic signed [COMP_WIDTH-1:0] MIN_NEG = {1'b1, {(COMP_WIDTH-1){1'b0}}};

   // A reset cycle leaves the result side empty.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // With the output register empty, every stage can move, so input is taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the pipeline output is empty");

   // A clipped result carries at least one component at a range limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && saturated) |->
         (r_x == MAX_POS || r_x == MIN_NEG || r_y == MAX_POS || r_y == MIN_NEG ||
          r_z == MAX_POS || r_z == MIN_NEG || r_w == MAX_POS || r_w == MIN_NEG))
      else $error("saturated flag without a component at a range limit");

   // A stalled result word holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(r_w)
          && $stable(q_flipped) && $stable(saturated)))
      else $error("stalled result word changed");

   // Out of reset, the handshake signals on both sides are always known.
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_ready, rsp_valid, rsp_ready}))
      else $error("unknown value on a handshake signal");
endmodule

bind quaternion_align_multiply_core qam_checker #(
   .COMP_WIDTH (COMP_WIDTH)
) u_qam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .r_x       (rsp_chan.r_x),
   .r_y       (rsp_chan.r_y),
   .r_z       (rsp_chan.r_z),
   .r_w       (rsp_chan.r_w),
   .q_flipped (rsp_chan.q_flipped),
   .saturated (rsp_chan.saturated)
);

`default_nettype wire
